// ----- hdl/activation_to_category_select_defines.svh -----
`ifndef ACTIVATION_TO_CATEGORY_SELECT_DEFINES_SVH
`define ACTIVATION_TO_CATEGORY_SELECT_DEFINES_SVH

// Checked property, sampled on clock, off while reset is high
`define ACTCAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property of the form "pre gives post in the next cycle"
`define ACTCAT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

// ----- hdl/actcat_pkg.sv -----
`default_nettype none

package actcat_pkg;

   // default sizing
   localparam int MAX_OUTPUTS_DEF = 64;
   localparam int ACT_WIDTH_DEF   = 16;

   // fixed field widths
   localparam int FRAC_W     = 16;
   localparam int CAT_W      = 6;
   localparam int CHOSEN_W   = 16;
   localparam int RSP_DATA_W = ((CAT_W + CHOSEN_W + 7) / 8) * 8;

   // configuration port
   localparam int NUM_W      = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_ADDR_W-1:0] REG_SELECT_MODE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_OUTPUTS = 1'd1;

   localparam logic [NUM_W-1:0] NUM_OUTPUTS_RST = 7'd64;

   localparam logic MODE_ARGMAX     = 1'b0;
   localparam logic MODE_STOCHASTIC = 1'b1;

   // roulette walk sequencer
   typedef enum logic [2:0] {
      WALK_IDLE = 3'b001,
      WALK_MULT = 3'b010,
      WALK_SCAN = 3'b100
   } walk_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } walk_status_type;

endpackage

`default_nettype wire

// ----- hdl/actcat_ram.sv -----
`default_nettype none

module actcat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/actcat_walk.sv -----
`default_nettype none
`include "activation_to_category_select_defines.svh"

module actcat_walk #(
   parameter int MAX_OUTPUTS = actcat_pkg::MAX_OUTPUTS_DEF,
   parameter int ACT_WIDTH   = actcat_pkg::ACT_WIDTH_DEF
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         start,
   input  wire logic [actcat_pkg::FRAC_W-1:0]                frac,
   input  wire logic [ACT_WIDTH+$clog2(MAX_OUTPUTS)-1:0]     total,
   input  wire logic [$clog2(MAX_OUTPUTS)-1:0]               last_idx,
   output logic                                              rd_en,
   output logic      [$clog2(MAX_OUTPUTS)-1:0]               rd_addr,
   input  wire logic [ACT_WIDTH-1:0]                         rd_data,
   output actcat_pkg::walk_status_type                       status,
   output logic      [$clog2(MAX_OUTPUTS)-1:0]               pick_idx,
   output logic      [ACT_WIDTH-1:0]                         pick_value
);

   localparam int IDX_W = $clog2(MAX_OUTPUTS);
   localparam int TOT_W = ACT_WIDTH + IDX_W;
   localparam int TGT_W = actcat_pkg::FRAC_W + TOT_W;

   actcat_pkg::walk_state_type state_ff, state_in;

   logic [actcat_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [TOT_W-1:0]              total_ff, total_in;
   logic [IDX_W-1:0]              last_ff, last_in;
   logic [TGT_W-1:0]              target_ff, target_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [TOT_W-1:0]              running_ff, running_in;
   logic [TOT_W-1:0]              sum;
   logic                          hit;
   logic                          done;

   // shared adder and compare: one stored element per cycle
   assign sum = running_ff + TOT_W'(rd_data);
   assign hit = target_ff < {sum, {actcat_pkg::FRAC_W{1'b0}}};

   // sequencer
   always_comb begin
      state_in   = state_ff;
      frac_in    = frac_ff;
      total_in   = total_ff;
      last_in    = last_ff;
      target_in  = target_ff;
      idx_in     = idx_ff;
      running_in = running_ff;
      rd_en      = 1'b0;
      rd_addr    = IDX_W'(idx_ff + 1'b1);
      done       = 1'b0;
      case (state_ff)
         actcat_pkg::WALK_IDLE: begin
            if (start) begin
               frac_in  = frac;
               total_in = total;
               last_in  = last_idx;
               state_in = actcat_pkg::WALK_MULT;
            end
         end
         actcat_pkg::WALK_MULT: begin
            // threshold = fraction * row total, first entry fetched meanwhile
            target_in  = TGT_W'(frac_ff) * TGT_W'(total_ff);
            idx_in     = '0;
            running_in = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_in   = actcat_pkg::WALK_SCAN;
         end
         actcat_pkg::WALK_SCAN: begin
            if (hit || (idx_ff == last_ff)) begin
               done     = 1'b1;
               state_in = actcat_pkg::WALK_IDLE;
            end else begin
               idx_in     = IDX_W'(idx_ff + 1'b1);
               running_in = sum;
               rd_en      = 1'b1;
            end
         end
         default: begin
            state_in = actcat_pkg::WALK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= actcat_pkg::WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      frac_ff    <= frac_in;
      total_ff   <= total_in;
      last_ff    <= last_in;
      target_ff  <= target_in;
      idx_ff     <= idx_in;
      running_ff <= running_in;
   end

   assign status.busy = (state_ff != actcat_pkg::WALK_IDLE);
   assign status.done = done;
   assign pick_idx    = idx_ff;
   assign pick_value  = rd_data;

   `ACTCAT_ASSERT(a_scan_in_row, (state_ff == actcat_pkg::WALK_SCAN) |-> (idx_ff <= last_ff), "walk index past row end")
   `ACTCAT_ASSERT(a_start_idle, start |-> (state_ff == actcat_pkg::WALK_IDLE), "walk started while busy")
   `ACTCAT_ASSERT_NEXT(a_done_idle, done, (state_ff == actcat_pkg::WALK_IDLE), "walk did not return to idle")

endmodule

`default_nettype wire

// ----- hdl/activation_to_category_select.sv -----
// Winner-take-all mode: one element per cycle while no earlier result waits at a row's
//   last beat; the result is registered on that beat. Stochastic mode: after the last beat
//   a multiply forms the threshold while the first entry is fetched, then a walk over
//   the single read port of the row memory up to the picked index k registers the result.
// Reset (synchronous, active high) clears counters, sequencer and the output valid flag,
//   sets select_mode to 0 and num_outputs to 64; the row memory is not cleared.
`default_nettype none
`include "activation_to_category_select_defines.svh"

module activation_to_category_select #(
   parameter int MAX_OUTPUTS = actcat_pkg::MAX_OUTPUTS_DEF,
   parameter int ACT_WIDTH   = actcat_pkg::ACT_WIDTH_DEF
) (
   input  wire logic                                                       clock,
   input  wire logic                                                       reset,
   // req_tdata: activation_value, random_fraction, zero pad
   input  wire logic                                                       req_tvalid,
   output logic                                                            req_tready,
   input  wire logic [((ACT_WIDTH+actcat_pkg::FRAC_W+7)/8)*8-1:0]          req_tdata,
   // rsp_tdata: category_index, chosen_activation, zero pad
   output logic                                                            rsp_tvalid,
   input  wire logic                                                       rsp_tready,
   output logic      [actcat_pkg::RSP_DATA_W-1:0]                          rsp_tdata,
   input  wire logic                                                       csr_we,
   input  wire logic [actcat_pkg::CSR_ADDR_W-1:0]                          csr_addr,
   input  wire logic [actcat_pkg::CSR_DATA_W-1:0]                          csr_wdata
);

   localparam int IDX_W = $clog2(MAX_OUTPUTS);
   localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
   localparam int TOT_W = ACT_WIDTH + IDX_W;

   logic                          mode_ff, mode_in;
   logic [actcat_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [ACT_WIDTH-1:0]          best_ff, best_in;
   logic [IDX_W-1:0]              bpos_ff, bpos_in;
   logic [TOT_W-1:0]              total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]              rsp_idx_ff, rsp_idx_in;
   logic [ACT_WIDTH-1:0]          rsp_act_ff, rsp_act_in;

   logic [CNT_W-1:0]              len;
   logic [CNT_W-1:0]              last_pos;
   logic [CNT_W-1:0]              pos;
   logic                          is_last;
   logic                          accept;
   logic [ACT_WIDTH-1:0]          act;
   logic [actcat_pkg::FRAC_W-1:0] frac;
   logic [ACT_WIDTH-1:0]          nbest;
   logic [IDX_W-1:0]              nbpos;
   logic [TOT_W-1:0]              ntot;
   logic                          walk_start;

   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [ACT_WIDTH-1:0]          rd_data;
   actcat_pkg::walk_status_type   walk_status;
   logic [IDX_W-1:0]              walk_idx;
   logic [ACT_WIDTH-1:0]          walk_value;

   assign act  = req_tdata[ACT_WIDTH-1:0];
   assign frac = req_tdata[ACT_WIDTH +: actcat_pkg::FRAC_W];

   // effective row length: 0 acts as 1, clamp to the memory depth
   always_comb begin
      if (num_ff == '0) begin
         len = CNT_W'(1);
      end else if (int'(num_ff) > MAX_OUTPUTS) begin
         len = CNT_W'(MAX_OUTPUTS);
      end else begin
         len = CNT_W'(num_ff);
      end
   end

   assign last_pos = CNT_W'(len - 1'b1);
   assign pos      = (count_ff >= len) ? last_pos : count_ff;
   assign is_last  = (pos == last_pos);

   // hold off every beat during a walk, and a row-closing beat while the previous result is still waiting
   assign req_tready = !walk_status.busy && !(rsp_valid_ff && is_last);
   assign accept     = req_tvalid && req_tready;
   assign walk_start = accept && is_last && (mode_ff == actcat_pkg::MODE_STOCHASTIC);

   // running maximum and sum
   always_comb begin
      if (pos == '0) begin
         nbest = act;
         nbpos = '0;
         ntot  = TOT_W'(act);
      end else begin
         nbest = (act > best_ff) ? act : best_ff;
         nbpos = (act > best_ff) ? pos[IDX_W-1:0] : bpos_ff;
         ntot  = total_ff + TOT_W'(act);
      end
   end

   // next state of row tracking, configuration and output register
   always_comb begin
      mode_in      = mode_ff;
      num_in       = num_ff;
      count_in     = count_ff;
      best_in      = best_ff;
      bpos_in      = bpos_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_act_in   = rsp_act_ff;

      if (csr_we) begin
         case (csr_addr)
            actcat_pkg::REG_SELECT_MODE: mode_in = csr_wdata[0];
            actcat_pkg::REG_NUM_OUTPUTS: num_in  = csr_wdata[actcat_pkg::NUM_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (is_last) begin
            count_in = '0;
            best_in  = '0;
            bpos_in  = '0;
            total_in = '0;
         end else begin
            count_in = CNT_W'(pos + 1'b1);
            best_in  = nbest;
            bpos_in  = nbpos;
            total_in = ntot;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (walk_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = walk_idx;
         rsp_act_in   = walk_value;
      end else if (accept && is_last && (mode_ff == actcat_pkg::MODE_ARGMAX)) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = nbpos;
         rsp_act_in   = nbest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= actcat_pkg::MODE_ARGMAX;
         num_ff       <= actcat_pkg::NUM_OUTPUTS_RST;
         count_ff     <= '0;
         best_ff      <= '0;
         bpos_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         num_ff       <= num_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         bpos_ff      <= bpos_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_idx_ff <= rsp_idx_in;
      rsp_act_ff <= rsp_act_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = actcat_pkg::RSP_DATA_W'({actcat_pkg::CHOSEN_W'(rsp_act_ff),
                                                 actcat_pkg::CAT_W'(rsp_idx_ff)});

   // row memory
   actcat_ram #(
      .WIDTH (ACT_WIDTH),
      .DEPTH (MAX_OUTPUTS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos[IDX_W-1:0]),
      .wr_data (act),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // roulette walk
   actcat_walk #(
      .MAX_OUTPUTS (MAX_OUTPUTS),
      .ACT_WIDTH   (ACT_WIDTH)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .start      (walk_start),
      .frac       (frac),
      .total      (ntot),
      .last_idx   (pos[IDX_W-1:0]),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .status     (walk_status),
      .pick_idx   (walk_idx),
      .pick_value (walk_value)
   );

   `ACTCAT_ASSERT(a_no_beat_in_walk, walk_status.busy |-> !req_tready, "beat taken during walk")
   `ACTCAT_ASSERT(a_walk_rsp_free, walk_status.done |-> !rsp_valid_ff, "walk result overwrites pending result")
   `ACTCAT_ASSERT(a_count_bound, int'(count_ff) < MAX_OUTPUTS, "element count past row depth")

endmodule

`default_nettype wire
